>>> rtl/core/transfer_rate_pacer_core_assert.svh
// Assertion macros shared by the pacer RTL.
`ifndef TRANSFER_RATE_PACER_CORE_ASSERT_SVH
`define TRANSFER_RATE_PACER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/trp_pkg.sv
package trp_pkg;

  localparam int SENT_W = 40;
  localparam int MS_W   = 32;
  localparam int RATE_W = 32;
  localparam int SLEEP_W = 32;
  localparam int WIN_W  = 16;
  localparam int UTIL_W = 7;
  localparam int MINR_W = 21;
  localparam int MODE_W = 2;
  localparam int OP_W   = 2;

  // sent * 1000 * percent needs 57 bits; elapsed * 100 needs 39 bits
  localparam int DVD_W = 57;
  localparam int DVS_W = 39;
  localparam int CNT_W = $clog2(DVD_W);

  localparam int MS_PER_S  = 1000;
  localparam int PCT_SCALE = 100;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [WIN_W-1:0]  WINDOW_RST = WIN_W'(3000);
  localparam logic [UTIL_W-1:0] UTIL_RST   = UTIL_W'(50);
  localparam logic [MINR_W-1:0] MINR_RST   = MINR_W'(5 * 1024);

  localparam logic [OP_W-1:0] OP_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_DISABLED   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ESTIMATING = 2'd1;
  localparam logic [MODE_W-1:0] MODE_THROTTLING = 2'd2;

  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_UTIL   = 2'd1;
  localparam logic [1:0] REG_MINR   = 2'd2;

  typedef struct packed {
    logic [WIN_W-1:0]  estimate_window_ms;
    logic [UTIL_W-1:0] utilization_percent;
    logic [MINR_W-1:0] min_rate;
  } trp_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } trp_div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FIN,
    ST_DONE
  } trp_state_t;

endpackage

>>> rtl/core/trp_regs.sv
module trp_regs
  import trp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output trp_cfg_t          cfg
);

  trp_cfg_t   cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.estimate_window_ms  <= WINDOW_RST;
      cfg_r.utilization_percent <= UTIL_RST;
      cfg_r.min_rate            <= MINR_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WINDOW: cfg_r.estimate_window_ms  <= pwdata[WIN_W-1:0];
        REG_UTIL:   cfg_r.utilization_percent <= pwdata[UTIL_W-1:0];
        REG_MINR:   cfg_r.min_rate            <= pwdata[MINR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW: prdata = DATA_W'(cfg_r.estimate_window_ms);
      REG_UTIL:   prdata = DATA_W'(cfg_r.utilization_percent);
      REG_MINR:   prdata = DATA_W'(cfg_r.min_rate);
      default:    prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/trp_divider.sv
`include "transfer_rate_pacer_core_assert.svh"

// Restoring divider, one quotient bit per cycle.
module trp_divider
  import trp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output trp_div_stat_t    stat,
  output logic [DVD_W-1:0] quotient
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem_r, q_r[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    count_nxt = count_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    if (start) begin
      busy_nxt  = 1'b1;
      count_nxt = CNT_W'(DVD_W - 1);
      q_nxt     = dividend;
      rem_nxt   = '0;
      dvs_nxt   = divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the top bit drops safely
      rem_nxt   = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      q_nxt     = {q_r[DVD_W-2:0], ge};
      count_nxt = count_r - 1'b1;
      if (count_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      count_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

  `TRP_ASSERT_NOW(a_start_idle, start, !busy_r, "divider started while busy")
  `TRP_ASSERT_NEXT(a_last_step_done, busy_r && (count_r == '0) && !start, done_r && !busy_r,
    "divider missed its done pulse")
  `TRP_ASSERT_NOW(a_done_after_busy, done_r, $past(busy_r), "done without a running division")

endmodule

>>> rtl/core/transfer_rate_pacer_core.sv
// Upload pacer. Every accepted item yields exactly one result. Start, tick
// and reports that need no arithmetic go from acceptance to ST_DONE, which
// loads the output register once it is empty or being read. A report that
// fixes the rate goes through two multiply steps, a report that computes a
// sleep time through one, and both then use the shared 57-step serial
// divider before ST_FIN and ST_DONE. in_ready is high only while the sequencer
// is idle, but an item is taken while the previous result still waits in the
// output register.
`include "transfer_rate_pacer_core_assert.svh"

module transfer_rate_pacer_core
  import trp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [SENT_W-1:0]  in_total_sent_bytes,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SLEEP_W-1:0] out_sleep_ms,
  output logic [MODE_W-1:0]  out_mode,
  output logic [RATE_W-1:0]  out_current_rate,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  trp_cfg_t      cfg;
  trp_div_stat_t div_stat;
  logic [DVD_W-1:0] quotient;

  trp_state_t state_r, state_nxt;

  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [MS_W-1:0]    elapsed_r, elapsed_nxt;
  logic [SENT_W-1:0]  base_r, base_nxt;
  logic [RATE_W-1:0]  rate_r, rate_nxt;

  logic [SENT_W-1:0]  sent_r, sent_nxt;
  logic               est_r, est_nxt;
  logic [DVD_W-1:0]   prod_r, prod_nxt;
  logic [DVS_W-1:0]   den_r, den_nxt;
  logic [SLEEP_W-1:0] sleep_r, sleep_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [SLEEP_W-1:0] out_sleep_r, out_sleep_nxt;
  logic [MODE_W-1:0]  out_mode_r, out_mode_nxt;
  logic [RATE_W-1:0]  out_rate_r, out_rate_nxt;

  logic               div_start;
  logic               accept;
  logic [SENT_W-1:0]  net;
  logic [RATE_W-1:0]  rate_div;
  logic [MINR_W-1:0]  floor_rate;
  logic [DVD_W-1:0]   est_rate;
  logic [DVD_W-1:0]   sleep_raw;

  trp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  trp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (den_r),
    .stat     (div_stat),
    .quotient (quotient)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign net        = (sent_r > base_r) ? (sent_r - base_r) : '0;
  assign rate_div   = (rate_r == '0) ? RATE_W'(1) : rate_r;
  assign floor_rate = (cfg.min_rate == '0) ? MINR_W'(1) : cfg.min_rate;
  assign est_rate   = (quotient < DVD_W'(floor_rate)) ? DVD_W'(floor_rate) : quotient;
  assign sleep_raw  = quotient - DVD_W'(elapsed_r);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    elapsed_nxt   = elapsed_r;
    base_nxt      = base_r;
    rate_nxt      = rate_r;
    sent_nxt      = sent_r;
    est_nxt       = est_r;
    prod_nxt      = prod_r;
    den_nxt       = den_r;
    sleep_nxt     = sleep_r;
    out_valid_nxt = out_valid_r;
    out_sleep_nxt = out_sleep_r;
    out_mode_nxt  = out_mode_r;
    out_rate_nxt  = out_rate_r;
    div_start     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sent_nxt  = in_total_sent_bytes;
          sleep_nxt = '0;
          state_nxt = ST_DONE;
          case (in_opcode)
            OP_START: begin
              elapsed_nxt = '0;
              base_nxt    = '0;
              mode_nxt    = (rate_r == '0) ? MODE_ESTIMATING : MODE_THROTTLING;
            end
            OP_TICK: begin
              if (elapsed_r != '1) begin
                elapsed_nxt = elapsed_r + 1'b1;
              end
            end
            OP_REPORT: begin
              if (mode_r == MODE_ESTIMATING &&
                  elapsed_r > MS_W'(cfg.estimate_window_ms)) begin
                est_nxt   = 1'b1;
                state_nxt = ST_MUL1;
              end else if (mode_r == MODE_THROTTLING) begin
                est_nxt   = 1'b0;
                state_nxt = ST_MUL1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MUL1: begin
        if (est_r) begin
          prod_nxt  = DVD_W'(sent_r) * DVD_W'(MS_PER_S);
          den_nxt   = DVS_W'(elapsed_r) * DVS_W'(PCT_SCALE);
          state_nxt = ST_MUL2;
        end else begin
          prod_nxt  = DVD_W'(net) * DVD_W'(MS_PER_S);
          den_nxt   = DVS_W'(rate_div);
          state_nxt = ST_DIV_GO;
        end
      end
      ST_MUL2: begin
        prod_nxt  = prod_r * DVD_W'(cfg.utilization_percent);
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (est_r) begin
          rate_nxt    = (|est_rate[DVD_W-1:RATE_W]) ? '1 : est_rate[RATE_W-1:0];
          base_nxt    = sent_r;
          elapsed_nxt = '0;
          mode_nxt    = MODE_THROTTLING;
        end else if (quotient > DVD_W'(elapsed_r)) begin
          sleep_nxt = (|sleep_raw[DVD_W-1:SLEEP_W]) ? '1 : sleep_raw[SLEEP_W-1:0];
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_sleep_nxt = sleep_r;
          out_mode_nxt  = mode_r;
          out_rate_nxt  = rate_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_DISABLED;
      elapsed_r   <= '0;
      base_r      <= '0;
      rate_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      elapsed_r   <= elapsed_nxt;
      base_r      <= base_nxt;
      rate_r      <= rate_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sent_r      <= sent_nxt;
    est_r       <= est_nxt;
    prod_r      <= prod_nxt;
    den_r       <= den_nxt;
    sleep_r     <= sleep_nxt;
    out_sleep_r <= out_sleep_nxt;
    out_mode_r  <= out_mode_nxt;
    out_rate_r  <= out_rate_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sleep_ms     = out_sleep_r;
  assign out_mode         = out_mode_r;
  assign out_current_rate = out_rate_r;

  `TRP_ASSERT_NOW(a_throttle_has_rate, mode_r == MODE_THROTTLING, rate_r != '0,
    "throttling without a rate")
  `TRP_ASSERT_NEXT(a_one_item_at_a_time, accept, !in_ready, "second item taken mid-transfer")
  `TRP_ASSERT_NOW(a_done_while_waiting, div_stat.done, state_r == ST_DIV_WAIT,
    "divider result arrived outside the wait state")
  `TRP_ASSERT_NOW(a_idle_div_quiet, state_r == ST_IDLE, !div_stat.busy,
    "divider running while idle")

endmodule
